// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hop_pkg.sv
// ----------------------------------------------------------------------------
// hop_pkg
// Widths, codes and state type shared by the hopalong point generator.
// ----------------------------------------------------------------------------
package hop_pkg;

    // Interface widths
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CTR_W      = 12;
    localparam int CNT_W      = 13;
    localparam int PT_W       = 32;

    // State widths
    localparam int COORD_W    = 48;
    localparam int BUDGET_W   = 19;

    // Budget scaling
    localparam int PPC_W = 7;
    localparam logic [PPC_W-1:0]    POINTS_PER_COUNT = 7'd100;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX       = 19'h7FFFF;

    // Iterative multiplier: magnitude of i times magnitude of b
    localparam int MUL_A_W    = COORD_W;
    localparam int MUL_B_W    = CFG_W;
    localparam int MUL_CHUNK  = 24;
    localparam int MUL_STEPS  = MUL_A_W / MUL_CHUNK;
    localparam int MUL_STEP_W = $clog2(MUL_STEPS + 1);
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Product cap and difference widths
    localparam int MAG_W      = 63;
    localparam int DIFF_W     = 64;
    localparam int CAP_BIT    = 62;

    // Reset values of the configuration registers
    localparam logic [CTR_W-1:0] CENTER_X_RST = 12'd512;
    localparam logic [CTR_W-1:0] CENTER_Y_RST = 12'd384;
    localparam logic [CNT_W-1:0] COUNT_RST    = 13'd2000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARAM_A  = 3'd0,
        REG_PARAM_B  = 3'd1,
        REG_PARAM_C  = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_COUNT    = 3'd5
    } hop_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CAP,
        ST_DIFF,
        ST_MAG,
        ST_ROOT,
        ST_UPD,
        ST_SUM,
        ST_PIX,
        ST_EMIT
    } hop_state_t;

endpackage

// File: rtl/hopalong_attractor_point_generator_unit.sv
// ----------------------------------------------------------------------------
// hopalong_attractor_point_generator_unit
// Fixed-point hopalong (Martin map) point generator with screen mapping.
// ----------------------------------------------------------------------------
// A restart word (restart = 1) clears both coordinates and loads a budget of
// count_hundreds * 100 points (at most 2^19 - 1) when accepted, with no result.
// Each tick word (restart = 0) steps the map once and returns one screen
// point, until the budget is spent; a tick with an empty budget returns
// nothing. ROOT_W = (63 + FRAC_BITS + 1) / 2, rounded down to an integer, is
// the width of the root; the shared square root unit resolves one root bit
// per cycle, and the 48 x 32 product is built on a 24 x 32 multiplier. The
// input stalls while a tick is in flight and a finished point waits in the
// output register, so the next word is accepted while that point is still
// pending.
module hopalong_attractor_point_generator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [hop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hop_pkg::CFG_W-1:0]          cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               restart,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hop_pkg::PT_W-1:0]    point_x,
    output logic signed [hop_pkg::PT_W-1:0]    point_y,
    output logic                               last_point
);
    import hop_pkg::*;

    `include "assert_macros.svh"

    localparam int RAD_W  = ((MAG_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int OFF_W  = COORD_W + 1 - FRAC_BITS;
    localparam int SAT_W  = (OFF_W + 1 > PT_W + 1) ? OFF_W + 1 : PT_W + 1;
    localparam int BUD_W  = CNT_W + PPC_W;

    localparam logic [PROD_W-1:0]       PROD_CAP = PROD_W'(1) << CAP_BIT;
    localparam logic signed [SAT_W-1:0] PT_MAX   = SAT_W'(2147483647);
    localparam logic signed [SAT_W-1:0] PT_MIN   = ~PT_MAX;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [COORD_W:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v[COORD_W] != v[COORD_W-1])
            r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    // Divide by 2^FRAC_BITS, rounding toward zero
    function automatic logic signed [OFF_W-1:0] to_pixels(
        input logic signed [COORD_W:0] v
    );
        logic signed [COORD_W:0] sh;
        logic                    bump;
        sh   = v >>> FRAC_BITS;
        bump = v[COORD_W] && (v[FRAC_BITS-1:0] != '0);
        sh   = sh + (COORD_W+1)'(bump);
        return sh[OFF_W-1:0];
    endfunction

    function automatic logic signed [PT_W-1:0] sat_point(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [PT_W-1:0] r;
        if (v > PT_MAX)
            r = PT_MAX[PT_W-1:0];
        else if (v < PT_MIN)
            r = PT_MIN[PT_W-1:0];
        else
            r = v[PT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    hop_state_t state_reg;
    hop_state_t state_next;

    logic signed [CFG_W-1:0]   param_a_reg;
    logic signed [CFG_W-1:0]   param_b_reg;
    logic signed [CFG_W-1:0]   param_c_reg;
    logic [CTR_W-1:0]          center_x_reg;
    logic [CTR_W-1:0]          center_y_reg;
    logic [CNT_W-1:0]          count_reg;

    logic signed [COORD_W-1:0] coord_i_reg;
    logic signed [COORD_W-1:0] coord_j_reg;
    logic [BUDGET_W-1:0]       points_left_reg;

    logic signed [COORD_W-1:0] new_j_reg;
    logic signed [DIFF_W-1:0]  prod_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [COORD_W:0]   sum_reg;
    logic signed [COORD_W:0]   dif_reg;
    logic signed [OFF_W-1:0]   off_x_reg;
    logic signed [OFF_W-1:0]   off_y_reg;

    logic                      out_valid_reg;
    logic signed [PT_W-1:0]    point_x_reg;
    logic signed [PT_W-1:0]    point_y_reg;
    logic                      last_point_reg;

    logic                      in_accept;
    logic                      tick_go;
    logic                      out_free;
    logic                      mul_start;
    logic                      sqrt_start;
    logic                      out_load;

    logic [MUL_A_W-1:0]        mag_i;
    logic [MUL_B_W-1:0]        mag_b;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_product;
    logic                      sqrt_done;
    logic [ROOT_W-1:0]         sqrt_root;

    logic [BUD_W-1:0]          budget_w;
    logic [BUDGET_W-1:0]       budget;
    logic [PROD_W-1:0]         prod_sh;
    logic [MAG_W-1:0]          prod_mag;
    logic                      prod_neg;
    logic signed [DIFF_W-1:0]  prod_s;
    logic [DIFF_W-1:0]         diff_mag;
    logic [RAD_W-1:0]          rad_in;
    logic signed [COORD_W:0]   j_ext;
    logic signed [COORD_W:0]   i_ext;
    logic signed [COORD_W:0]   root_ext;
    logic signed [COORD_W:0]   new_i_w;
    logic signed [COORD_W:0]   new_j_w;
    logic signed [SAT_W-1:0]   x_w;
    logic signed [SAT_W-1:0]   y_w;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign in_accept = in_valid && !in_stall;
    assign tick_go   = in_accept && !restart && (points_left_reg != '0);
    assign out_free  = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_a_reg  <= '0;
            param_b_reg  <= '0;
            param_c_reg  <= '0;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            count_reg    <= COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PARAM_A:  param_a_reg  <= cfg_data;
                REG_PARAM_B:  param_b_reg  <= cfg_data;
                REG_PARAM_C:  param_c_reg  <= cfg_data;
                REG_CENTER_X: center_x_reg <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CTR_W-1:0];
                REG_COUNT:    count_reg    <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (tick_go)   state_next = ST_MUL;
            ST_MUL:  if (mul_done)  state_next = ST_CAP;
            ST_CAP:                 state_next = ST_DIFF;
            ST_DIFF:                state_next = ST_MAG;
            ST_MAG:                 state_next = ST_ROOT;
            ST_ROOT: if (sqrt_done) state_next = ST_UPD;
            ST_UPD:                 state_next = ST_SUM;
            ST_SUM:                 state_next = ST_PIX;
            ST_PIX:                 state_next = ST_EMIT;
            ST_EMIT: if (out_free)  state_next = ST_IDLE;
            default:                state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_stall   = 1'b1;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                mul_start = in_valid && !restart && (points_left_reg != '0);
            end
            ST_MAG:  sqrt_start = 1'b1;
            ST_EMIT: out_load   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    assign mag_i = coord_i_reg[COORD_W-1] ? MUL_A_W'(-coord_i_reg) : MUL_A_W'(coord_i_reg);
    assign mag_b = param_b_reg[CFG_W-1]   ? MUL_B_W'(-param_b_reg) : MUL_B_W'(param_b_reg);

    hop_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag_i),
        .b       (mag_b),
        .done    (mul_done),
        .product (mul_product)
    );

    hop_sqrt #(
        .RAD_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rad_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ------------------------------------------------------------------
    // Step arithmetic
    // ------------------------------------------------------------------
    always_comb
    begin
        // budget load, saturated
        budget_w = count_reg * POINTS_PER_COUNT;
        budget   = (budget_w > BUD_W'(BUDGET_MAX)) ? BUDGET_MAX : budget_w[BUDGET_W-1:0];

        // drop fraction bits of |b*i| and cap the magnitude, then sign it
        prod_sh  = mul_product >> FRAC_BITS;
        prod_mag = (prod_sh > PROD_CAP) ? PROD_CAP[MAG_W-1:0] : prod_sh[MAG_W-1:0];
        prod_neg = coord_i_reg[COORD_W-1] ^ param_b_reg[CFG_W-1];
        prod_s   = prod_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

        // radicand is |b*i - c| scaled up by the fraction bits
        diff_mag = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        rad_in   = RAD_W'({diff_mag[MAG_W-1:0], {FRAC_BITS{1'b0}}});

        // coordinate updates, one bit wider before saturation
        i_ext    = {coord_i_reg[COORD_W-1], coord_i_reg};
        j_ext    = {coord_j_reg[COORD_W-1], coord_j_reg};
        root_ext = $signed((COORD_W+1)'(sqrt_root));
        new_i_w  = coord_i_reg[COORD_W-1] ? (j_ext + root_ext) : (j_ext - root_ext);
        new_j_w  = $signed({{(COORD_W+1-CFG_W){param_a_reg[CFG_W-1]}}, param_a_reg}) - i_ext;

        // screen position
        x_w = $signed(SAT_W'(center_x_reg)) + SAT_W'(off_x_reg);
        y_w = $signed(SAT_W'(center_y_reg)) - SAT_W'(off_y_reg);
    end

    // Map state and budget
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_i_reg     <= '0;
            coord_j_reg     <= '0;
            points_left_reg <= '0;
        end
        else if (in_accept && restart)
        begin
            coord_i_reg     <= '0;
            coord_j_reg     <= '0;
            points_left_reg <= budget;
        end
        else if (state_reg == ST_UPD)
        begin
            coord_i_reg     <= sat_coord(new_i_w);
            coord_j_reg     <= new_j_reg;
            points_left_reg <= points_left_reg - BUDGET_W'(1);
        end
    end

    // Intermediate results, registered in the CAP, DIFF, SUM and PIX states
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CAP:
            begin
                prod_reg  <= prod_s;
                new_j_reg <= sat_coord(new_j_w);
            end
            ST_DIFF: diff_reg <= prod_reg - DIFF_W'(param_c_reg);
            ST_SUM:
            begin
                sum_reg <= i_ext + j_ext;
                dif_reg <= i_ext - j_ext;
            end
            ST_PIX:
            begin
                off_x_reg <= to_pixels(sum_reg);
                off_y_reg <= to_pixels(dif_reg);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            point_x_reg    <= sat_point(x_w);
            point_y_reg    <= sat_point(y_w);
            last_point_reg <= (points_left_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_point_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_mul_done_in_mul, mul_done, state_reg == ST_MUL, "multiplier done outside MUL")
    `ASSERT_IMPL(a_root_done_in_root, sqrt_done, state_reg == ST_ROOT, "root done outside ROOT")
    `ASSERT_NEXT(a_tick_starts, tick_go, state_reg == ST_MUL, "live tick did not start a step")
    `ASSERT_NEXT(a_last_flag, out_load, out_valid_reg && (last_point_reg == (points_left_reg == '0)), "last point flag disagrees with budget")

endmodule

// File: rtl/hop_mul.sv
// ----------------------------------------------------------------------------
// hop_mul
// Unsigned multiplier that takes one chunk of the wide operand per cycle,
// high chunk first, and accumulates the partial products.
// ----------------------------------------------------------------------------
module hop_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hop_pkg::MUL_A_W-1:0] a,
    input  logic [hop_pkg::MUL_B_W-1:0] b,
    output logic                        done,
    output logic [hop_pkg::PROD_W-1:0]  product
);
    import hop_pkg::*;

    logic [MUL_A_W-1:0]           a_reg;
    logic [MUL_B_W-1:0]           b_reg;
    logic [PROD_W-1:0]            acc_reg;
    logic [PROD_W-1:0]            acc_next;
    logic [MUL_CHUNK+MUL_B_W-1:0] pp;
    logic [MUL_STEP_W-1:0]        step_reg;
    logic                         busy_reg;
    logic                         done_reg;

    // Partial product of the top chunk, folded into the shifted sum
    assign pp       = a_reg[MUL_A_W-1 -: MUL_CHUNK] * b_reg;
    assign acc_next = (acc_reg << MUL_CHUNK) + PROD_W'(pp);

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= MUL_STEP_W'(MUL_STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - MUL_STEP_W'(1);
                if (step_reg == MUL_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << MUL_CHUNK;
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/hop_sqrt.sv
// ----------------------------------------------------------------------------
// hop_sqrt
// Restoring integer square root: one root bit per cycle, floor of the
// exact root of an unsigned radicand.
// ----------------------------------------------------------------------------
module hop_sqrt #(
    parameter int RAD_W = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic               done,
    output logic [RAD_W/2-1:0] root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic              fits;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // Bring down the next bit pair and try to subtract 4*root + 1
    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[ROOT_W-2:0], fits};
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Radicand, remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
